[hdl/ctc_pkg.sv]
// Shared types and constants for the color threshold centroid block.
// No dependencies; every other file in hdl/ refers to this package.
`default_nettype none

package ctc_pkg;

  // Frame geometry limit.
  localparam int unsigned MAX_ROWS = 1024;
  localparam logic [9:0] ROW_LIMIT = (MAX_ROWS > 1024) ? 10'd1023 : 10'(MAX_ROWS - 1);

  // Saturation limits and widths.
  localparam int unsigned SUM_W  = 28;
  localparam int unsigned MOM_W  = 39;
  localparam int unsigned CENT_W = 14;
  localparam logic [CENT_W-1:0] CENT_MAX = '1;

  // Reset values of the configuration registers.
  localparam logic [10:0] FRAME_WIDTH_RESET = 11'd640;
  localparam logic [27:0] MIN_TOTAL_RESET   = 28'd0;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH = 1'b0,
    CFG_MIN_TOTAL   = 1'b1
  } cfg_idx_e;

  // Depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Quotient bits produced by the frame-end divider, one per step.
  localparam int unsigned DIV_STEPS = CENT_W;

  typedef struct packed {
    logic [7:0] blue_level;
    logic [7:0] green_level;
    logic [7:0] red_level;
    logic       last_pixel;
  } pix_t;

  typedef struct packed {
    logic [7:0]        gray_level;
    logic              frame_done;
    logic [CENT_W-1:0] centroid_col;
    logic [CENT_W-1:0] centroid_row;
    logic [SUM_W-1:0]  total_weight;
    logic              detected;
  } res_t;

  // One queued item: the pixel weight and, for the last pixel, the frame sums.
  typedef struct packed {
    logic [7:0]       gray;
    logic             last;
    logic [MOM_W-1:0] col_mom;
    logic [MOM_W-1:0] row_mom;
    logic [SUM_W-1:0] total;
    logic             detected;
  } job_t;

endpackage

`default_nettype wire

[hdl/ctc_front.sv]
// Front part: configuration registers, pixel weighting and frame accumulators.
// Depends on ctc_pkg; pushes one job per accepted pixel into the queue.
`default_nettype none

module ctc_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire ctc_pkg::cfg_idx_e cfg_idx_i,
  input  wire logic [27:0]       cfg_data_i,
  input  wire logic              in_valid_i,
  input  wire ctc_pkg::pix_t     in_data_i,
  input  wire logic              queue_full_i,
  output logic                   in_stall_o,
  output logic                   push_o,
  output ctc_pkg::job_t          job_o
);

  logic [10:0] frame_width_q;
  logic [27:0] min_total_q;
  logic [9:0]  col_cnt_q;
  logic [9:0]  row_cnt_q;
  logic [ctc_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [ctc_pkg::MOM_W-1:0] col_mom_q, col_mom_d;
  logic [ctc_pkg::MOM_W-1:0] row_mom_q, row_mom_d;

  logic signed [10:0] raw_w;
  logic [7:0]         weight;
  logic [17:0]        col_prod, row_prod;
  logic [ctc_pkg::SUM_W:0] sum_ext;
  logic [ctc_pkg::MOM_W:0] col_ext, row_ext;
  logic [10:0]        width_eff;
  logic               row_end;
  logic               accept;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign push_o     = accept;

  // The raw weight ranges from -1020 to 510, so 11 signed bits hold it.
  always_comb begin
    raw_w = $signed({2'b00, in_data_i.red_level, 1'b0})
          - $signed({3'b000, in_data_i.green_level})
          - $signed({2'b00, in_data_i.blue_level, 1'b0})
          - $signed({3'b000, in_data_i.blue_level});
    if (raw_w[10]) begin
      weight = 8'd0;
    end else if (raw_w[9:8] != 2'b00) begin
      weight = 8'd255;
    end else begin
      weight = raw_w[7:0];
    end
  end

  always_comb begin
    col_prod = weight * col_cnt_q;
    row_prod = weight * row_cnt_q;
    sum_ext  = {1'b0, sum_q} + (ctc_pkg::SUM_W + 1)'(weight);
    col_ext  = {1'b0, col_mom_q} + (ctc_pkg::MOM_W + 1)'(col_prod);
    row_ext  = {1'b0, row_mom_q} + (ctc_pkg::MOM_W + 1)'(row_prod);
    sum_d     = sum_ext[ctc_pkg::SUM_W] ? '1 : sum_ext[ctc_pkg::SUM_W-1:0];
    col_mom_d = col_ext[ctc_pkg::MOM_W] ? '1 : col_ext[ctc_pkg::MOM_W-1:0];
    row_mom_d = row_ext[ctc_pkg::MOM_W] ? '1 : row_ext[ctc_pkg::MOM_W-1:0];
  end

  always_comb begin
    if (frame_width_q == 11'd0) begin
      width_eff = 11'd1;
    end else if (frame_width_q > 11'd1024) begin
      width_eff = 11'd1024;
    end else begin
      width_eff = frame_width_q;
    end
    row_end = ({1'b0, col_cnt_q} + 11'd1) >= width_eff;
  end

  always_comb begin
    job_o.gray     = weight;
    job_o.last     = in_data_i.last_pixel;
    job_o.col_mom  = col_mom_d;
    job_o.row_mom  = row_mom_d;
    job_o.total    = sum_d;
    job_o.detected = sum_d > min_total_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q <= ctc_pkg::FRAME_WIDTH_RESET;
      min_total_q   <= ctc_pkg::MIN_TOTAL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ctc_pkg::CFG_FRAME_WIDTH: frame_width_q <= cfg_data_i[10:0];
        ctc_pkg::CFG_MIN_TOTAL:   min_total_q   <= cfg_data_i;
        default:                  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      sum_q     <= '0;
      col_mom_q <= '0;
      row_mom_q <= '0;
    end else if (accept) begin
      if (in_data_i.last_pixel) begin
        col_cnt_q <= '0;
        row_cnt_q <= '0;
        sum_q     <= '0;
        col_mom_q <= '0;
        row_mom_q <= '0;
      end else begin
        sum_q     <= sum_d;
        col_mom_q <= col_mom_d;
        row_mom_q <= row_mom_d;
        if (row_end) begin
          col_cnt_q <= '0;
          if (row_cnt_q < ctc_pkg::ROW_LIMIT) begin
            row_cnt_q <= row_cnt_q + 10'd1;
          end
        end else begin
          col_cnt_q <= col_cnt_q + 10'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[hdl/ctc_queue.sv]
// Short first-in first-out queue of jobs between the front and back parts.
// Depends on ctc_pkg for the job type and depth.
`default_nettype none

module ctc_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire ctc_pkg::job_t push_data_i,
  input  wire logic          pop_i,
  output logic               full_o,
  output logic               valid_o,
  output ctc_pkg::job_t      head_o
);

  ctc_pkg::job_t mem_q [ctc_pkg::QUEUE_DEPTH];
  logic [ctc_pkg::QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [ctc_pkg::QUEUE_AW:0]   count_q;
  logic do_push, do_pop;

  assign full_o  = count_q == (ctc_pkg::QUEUE_AW + 1)'(ctc_pkg::QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (ctc_pkg::QUEUE_AW + 1)'(ctc_pkg::QUEUE_DEPTH))
    else $error("queue fill count exceeds its depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_ptr_q == rd_ptr_q + count_q[ctc_pkg::QUEUE_AW-1:0])
    else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

[hdl/ctc_back.sv]
// Back part: passes ordinary pixels to the output register and runs the
// frame-end centroid divisions, one quotient bit per cycle. Depends on ctc_pkg.
`default_nettype none

module ctc_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          head_valid_i,
  input  wire ctc_pkg::job_t head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output ctc_pkg::res_t      out_data_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } state_e;

  state_e state_q;
  logic [3:0] step_q;
  logic       out_valid_q;
  ctc_pkg::res_t out_q;

  // Frame summary held while the divisions run.
  logic [7:0]                gray_q;
  logic [ctc_pkg::SUM_W-1:0] total_q;
  logic                      det_q;
  logic                      col_sat_q, row_sat_q;
  logic [ctc_pkg::SUM_W-1:0] col_rem_q, row_rem_q, col_rem_d, row_rem_d;
  logic [ctc_pkg::CENT_W-1:0] col_num_q, row_num_q;
  logic [ctc_pkg::CENT_W-1:0] col_quo_q, row_quo_q, col_quo_d, row_quo_d;

  logic out_free;
  logic load_out;
  logic head_sat_col, head_sat_row;
  logic [ctc_pkg::SUM_W:0] col_trial, row_trial;
  logic [ctc_pkg::CENT_W-1:0] col_final, row_final;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (state_q == S_IDLE) && head_valid_i && (head_i.last || out_free);
  assign load_out = ((state_q == S_IDLE) && pop_o && !head_i.last) ||
                    ((state_q == S_DONE) && out_free);

  // A quotient at or above 2^14 saturates; that is the case when the moment
  // reaches total * 2^10, before the four fraction bits are appended.
  assign head_sat_col = head_i.col_mom >= {1'b0, head_i.total, 10'd0};
  assign head_sat_row = head_i.row_mom >= {1'b0, head_i.total, 10'd0};

  // Restoring division step: shift in one numerator bit, subtract if it fits.
  always_comb begin
    col_trial = {col_rem_q, col_num_q[ctc_pkg::CENT_W-1]};
    row_trial = {row_rem_q, row_num_q[ctc_pkg::CENT_W-1]};
    if (col_trial >= {1'b0, total_q}) begin
      col_rem_d = ctc_pkg::SUM_W'(col_trial - {1'b0, total_q});
      col_quo_d = {col_quo_q[ctc_pkg::CENT_W-2:0], 1'b1};
    end else begin
      col_rem_d = col_trial[ctc_pkg::SUM_W-1:0];
      col_quo_d = {col_quo_q[ctc_pkg::CENT_W-2:0], 1'b0};
    end
    if (row_trial >= {1'b0, total_q}) begin
      row_rem_d = ctc_pkg::SUM_W'(row_trial - {1'b0, total_q});
      row_quo_d = {row_quo_q[ctc_pkg::CENT_W-2:0], 1'b1};
    end else begin
      row_rem_d = row_trial[ctc_pkg::SUM_W-1:0];
      row_quo_d = {row_quo_q[ctc_pkg::CENT_W-2:0], 1'b0};
    end
  end

  always_comb begin
    if (total_q == '0) begin
      col_final = '0;
      row_final = '0;
    end else begin
      col_final = col_sat_q ? ctc_pkg::CENT_MAX : col_quo_q;
      row_final = row_sat_q ? ctc_pkg::CENT_MAX : row_quo_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && pop_o && head_i.last) begin
      gray_q    <= head_i.gray;
      total_q   <= head_i.total;
      det_q     <= head_i.detected;
      col_sat_q <= head_sat_col;
      row_sat_q <= head_sat_row;
      col_rem_q <= head_i.col_mom[ctc_pkg::SUM_W+9:10];
      row_rem_q <= head_i.row_mom[ctc_pkg::SUM_W+9:10];
      col_num_q <= {head_i.col_mom[9:0], 4'd0};
      row_num_q <= {head_i.row_mom[9:0], 4'd0};
      col_quo_q <= '0;
      row_quo_q <= '0;
    end else if (state_q == S_DIV) begin
      col_rem_q <= col_rem_d;
      row_rem_q <= row_rem_d;
      col_num_q <= {col_num_q[ctc_pkg::CENT_W-2:0], 1'b0};
      row_num_q <= {row_num_q[ctc_pkg::CENT_W-2:0], 1'b0};
      col_quo_q <= col_quo_d;
      row_quo_q <= row_quo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            if (head_i.last) begin
              state_q <= S_DIV;
              step_q  <= '0;
            end else begin
              out_q <= '{gray_level: head_i.gray, frame_done: 1'b0, centroid_col: '0,
                         centroid_row: '0, total_weight: '0, detected: 1'b0};
            end
          end
        end
        S_DIV: begin
          if (step_q == 4'(ctc_pkg::DIV_STEPS - 1)) begin
            state_q <= S_DONE;
          end else begin
            step_q <= step_q + 4'd1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
            out_q   <= '{gray_level: gray_q, frame_done: 1'b1, centroid_col: col_final,
                         centroid_row: row_final, total_weight: total_q,
                         detected: (total_q != '0) && det_q};
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_summary_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.frame_done |->
      out_data_o.centroid_col == '0 && out_data_o.centroid_row == '0 &&
      out_data_o.total_weight == '0 && !out_data_o.detected)
    else $error("summary fields set on a pixel that does not end the frame");

  a_zero_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_done && out_data_o.total_weight == '0 |->
      out_data_o.centroid_col == '0 && out_data_o.centroid_row == '0 &&
      !out_data_o.detected)
    else $error("nonzero centroid or detection with zero total weight");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> step_q < 4'(ctc_pkg::DIV_STEPS))
    else $error("divider step count ran past the quotient width");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !pop_o)
    else $error("queue popped while a frame-end division is in progress");

endmodule

`default_nettype wire

[hdl/color_threshold_centroid_top.sv]
// Latency: an ordinary pixel's result is registered in the job queue, then in the
// output register; a frame's last pixel also has load, 14 divider steps and finish.
// Throughput: 1 pixel per cycle unless the queue is full or the output stalls;
// the frame-end divider busies the back part; a 4-entry queue hides part of that.
// Reset (rst_ni low, asynchronous) empties the queue and output register, clears
// counters and sums, and sets frame_width to 640 and the detection threshold to 0.
`default_nettype none

module color_threshold_centroid_top (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire ctc_pkg::cfg_idx_e cfg_idx_i,
  input  wire logic [27:0]       cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire ctc_pkg::pix_t     in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output ctc_pkg::res_t          out_data_o
);

  logic          push, pop, queue_full, head_valid;
  ctc_pkg::job_t push_job, head_job;

  ctc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .queue_full_i (queue_full),
    .in_stall_o   (in_stall_o),
    .push_o       (push),
    .job_o        (push_job)
  );

  ctc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .full_o      (queue_full),
    .valid_o     (head_valid),
    .head_o      (head_job)
  );

  ctc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire
